>>> hw/rtl/csthr_pkg.sv
package csthr_pkg;

    // countdown loaded on entry to the threshold delay state
    localparam logic [7:0] DELAY_TICKS = 8'd10;

    localparam logic [2:0] EV_APPLY = 3'd0;
    localparam logic [2:0] EV_START = 3'd1;
    localparam logic [2:0] EV_STOP  = 3'd2;
    localparam logic [2:0] EV_CLEAR = 3'd3;
    localparam logic [2:0] EV_TICK  = 3'd4;

    localparam logic [1:0] CFG_START_TIME   = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD_MV = 2'd1;
    localparam logic [1:0] CFG_SCHED_EN     = 2'd2;
    localparam logic [1:0] CFG_THRESH_EN    = 2'd3;

    localparam logic [2:0] CODE_IDLE     = 3'd0;
    localparam logic [2:0] CODE_SCHED    = 3'd1;
    localparam logic [2:0] CODE_CHARGING = 3'd2;
    localparam logic [2:0] CODE_DELAY    = 3'd3;
    localparam logic [2:0] CODE_COMPLETE = 3'd4;
    localparam logic [2:0] CODE_ERROR    = 3'd5;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SCHED    = 6'b000010,
        ST_CHARGING = 6'b000100,
        ST_DELAY    = 6'b001000,
        ST_COMPLETE = 6'b010000,
        ST_ERROR    = 6'b100000
    } t_mode;

    typedef struct packed {
        logic [31:0] start_time;
        logic [15:0] threshold_mv;
        logic        schedule_enable;
        logic        threshold_enable;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] now;
        logic [15:0] batt_mv;
        logic        time_synced;
    } t_item;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  countdown;
        logic        sched_flag;
        logic        relay;
    } t_state;

    function automatic logic [2:0] mode_code(input t_mode mode);
        logic [2:0] code;
        unique case (mode)
            ST_IDLE:     code = CODE_IDLE;
            ST_SCHED:    code = CODE_SCHED;
            ST_CHARGING: code = CODE_CHARGING;
            ST_DELAY:    code = CODE_DELAY;
            ST_COMPLETE: code = CODE_COMPLETE;
            ST_ERROR:    code = CODE_ERROR;
            default:     code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

>>> hw/rtl/charge_schedule_threshold_fsm.sv
// Channel  | Handshake               | Payload
// ---------+-------------------------+-----------------------------------------------
// event in | i_valid / o_ready       | i_kind, i_now, i_batt_mv, i_time_synced
// result   | o_valid / i_ready       | o_relay_on, o_state_code, o_delay_left,
//          |                         | o_schedule_active
// config   | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data (always ready)
//
// One event per cycle sustained while i_ready stays high; an accepted event passes
// through the input register, then the result register, with the state update between.
// Synchronous active-low reset returns the controller to idle with the relay open
// and clears all configuration registers.
// A stalled result holds; the input register keeps taking events as long as the
// result register can drain, so o_ready drops only when both stages are full.
module charge_schedule_threshold_fsm
    import csthr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_now,
    input  logic [15:0] i_batt_mv,
    input  logic        i_time_synced,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_relay_on,
    output logic [2:0]  o_state_code,
    output logic [7:0]  o_delay_left,
    output logic        o_schedule_active,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg   cfg;
    t_state next_state;
    t_item  r_in;
    logic   r_in_valid;
    logic   r_out_valid;
    logic   r_relay_on;
    logic [2:0] r_state_code;
    logic [7:0] r_delay_left;
    logic   r_schedule_active;
    logic   advance;

    assign o_cfg_ready = 1'b1;

    csthr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // move the held event into the result register
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in.kind        <= i_kind;
            r_in.now         <= i_now;
            r_in.batt_mv     <= i_batt_mv;
            r_in.time_synced <= i_time_synced;
        end
    end

    csthr_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .o_next    (next_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_relay_on        <= next_state.relay;
            r_state_code      <= mode_code(next_state.mode);
            r_delay_left      <= next_state.countdown;
            r_schedule_active <= next_state.sched_flag;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_relay_on        = r_relay_on;
    assign o_state_code      = r_state_code;
    assign o_delay_left      = r_delay_left;
    assign o_schedule_active = r_schedule_active;

endmodule

>>> hw/rtl/csthr_cfg.sv
module csthr_cfg
    import csthr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_TIME:   r_cfg.start_time       <= i_cfg_data;
                CFG_THRESHOLD_MV: r_cfg.threshold_mv     <= i_cfg_data[15:0];
                CFG_SCHED_EN:     r_cfg.schedule_enable  <= i_cfg_data[0];
                CFG_THRESH_EN:    r_cfg.threshold_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/csthr_fsm.sv
module csthr_fsm
    import csthr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_advance,
    input  t_item  i_item,
    input  t_cfg   i_cfg,
    output t_state o_next
);

    t_state r_state;
    t_state n_state;
    logic [7:0] dec_count;

    assign dec_count = r_state.countdown - 8'd1;

    always_comb begin
        n_state = r_state;
        case (i_item.kind)
            EV_APPLY: begin
                n_state.sched_flag = i_cfg.schedule_enable;
                n_state.countdown  = '0;
                if (i_cfg.schedule_enable && (i_cfg.start_time <= i_item.now)) begin
                    n_state.relay = 1'b1;
                    n_state.mode  = ST_CHARGING;
                end else if (i_cfg.schedule_enable) begin
                    n_state.relay = 1'b0;
                    n_state.mode  = ST_SCHED;
                end else begin
                    n_state.relay = 1'b0;
                    n_state.mode  = ST_IDLE;
                end
            end
            EV_START: begin
                n_state.relay     = 1'b1;
                n_state.countdown = '0;
                n_state.mode      = ST_CHARGING;
            end
            EV_STOP: begin
                n_state.relay      = 1'b0;
                n_state.countdown  = '0;
                n_state.sched_flag = 1'b0;
                n_state.mode       = ST_IDLE;
            end
            EV_CLEAR: begin
                n_state.sched_flag = 1'b0;
                n_state.countdown  = '0;
                if (r_state.mode == ST_SCHED) begin
                    n_state.mode = ST_IDLE;
                end
            end
            EV_TICK: begin
                unique case (r_state.mode)
                    ST_SCHED: begin
                        if (i_item.time_synced && (i_item.now >= i_cfg.start_time)) begin
                            n_state.relay = 1'b1;
                            n_state.mode  = ST_CHARGING;
                        end
                    end
                    ST_CHARGING: begin
                        if (i_cfg.threshold_enable
                                && (i_item.batt_mv >= i_cfg.threshold_mv)) begin
                            n_state.countdown = DELAY_TICKS;
                            n_state.mode      = ST_DELAY;
                        end
                    end
                    ST_DELAY: begin
                        // fall back regardless of threshold_enable
                        if (i_item.batt_mv < i_cfg.threshold_mv) begin
                            n_state.countdown = '0;
                            n_state.mode      = ST_CHARGING;
                        end else begin
                            // a cleared counter wraps through 255 here
                            n_state.countdown = dec_count;
                            if (dec_count == 8'd0) begin
                                n_state.relay      = 1'b0;
                                n_state.sched_flag = 1'b0;
                                n_state.mode       = ST_COMPLETE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode       <= ST_IDLE;
            r_state.countdown  <= '0;
            r_state.sched_flag <= 1'b0;
            r_state.relay      <= 1'b0;
        end else if (i_advance) begin
            r_state <= n_state;
        end
    end

    assign o_next = n_state;

endmodule
